>>> design/sspg_pkg.sv
// ----------------------------------------------------------------------------
// Sprite shape pixel generator package
// Shared codes, widths and the elaboration-time shape mask builders.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sspg_pkg;

    localparam int COORD_W   = 6;
    localparam int COORD_N   = 1 << COORD_W;
    localparam int LEVEL_W   = 8;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAPE_MODE  = 3'd0,
        CFG_RED_LEVEL   = 3'd1,
        CFG_GREEN_LEVEL = 3'd2,
        CFG_BLUE_LEVEL  = 3'd3,
        CFG_PEAK_ALPHA  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_DISC = 2'd0,
        MODE_STAR = 2'd1,
        MODE_BLOB = 2'd2
    } t_shape_mode;

    typedef struct packed {
        logic ld_mul;
        logic ld_out;
    } t_premul_ctl;

    // Star vertex directions in Q12; even vertices lie on the outer radius.
    localparam longint STAR_COS [10] = '{
        0, 2408, 3896, 3896, 2408, 0, -2408, -3896, -3896, -2408
    };
    localparam longint STAR_SIN [10] = '{
        -4096, -3314, -1266, 1266, 3314, 4096, 3314, 1266, -1266, -3314
    };

    // Blob ellipses in hundredths: center x, center y, radius x, radius y.
    localparam longint BLOB_ELL [4][4] = '{
        '{50, 82, 42, 18},
        '{50, 60, 33, 20},
        '{50, 40, 23, 18},
        '{55, 23, 12, 12}
    };

    function automatic logic f_star_hit(input int w, input int x, input int y);
        longint px;
        longint py;
        longint fi;
        longint fj;
        longint xi;
        longint yi;
        longint xj;
        longint yj;
        longint d;
        longint lhs;
        longint rhs;
        logic   in_poly;
        int     j;
        in_poly = 1'b0;
        j       = 9;
        px      = longint'(2 * x + 1 - w) * 64'sd4096000;
        py      = longint'(2 * y + 1 - w) * 64'sd4096000;
        for (int i = 0; i < 10; i++) begin
            fi = (i[0]) ? 64'sd361 : 64'sd950;
            fj = (j[0]) ? 64'sd361 : 64'sd950;
            xi = longint'(w) * fi * STAR_COS[i];
            yi = longint'(w) * fi * STAR_SIN[i];
            xj = longint'(w) * fj * STAR_COS[j];
            yj = longint'(w) * fj * STAR_SIN[j];
            if ((yi > py) != (yj > py)) begin
                d   = yj - yi;
                lhs = (px - xi) * d;
                rhs = (xj - xi) * (py - yi);
                if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) begin
                    in_poly = !in_poly;
                end
            end
            j = i;
        end
        return in_poly;
    endfunction

    function automatic logic f_blob_hit(input int w, input int x, input int y);
        longint u;
        longint v;
        longint rx;
        longint ry;
        longint wl;
        logic   hit;
        hit = 1'b0;
        wl  = longint'(w);
        for (int k = 0; k < 4; k++) begin
            u  = 64'sd100 * longint'(2 * x + 1) - 2 * wl * BLOB_ELL[k][0];
            v  = 64'sd100 * longint'(2 * y + 1) - 2 * wl * BLOB_ELL[k][1];
            rx = BLOB_ELL[k][2];
            ry = BLOB_ELL[k][3];
            if (u * u * ry * ry + v * v * rx * rx <= 4 * wl * wl * rx * rx * ry * ry) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [COORD_N-1:0] f_star_row(input int w, input int y);
        logic [COORD_N-1:0] row;
        row = '0;
        for (int x = 0; x < COORD_N; x++) begin
            row[x] = (x < w && y < w) ? f_star_hit(w, x, y) : 1'b0;
        end
        return row;
    endfunction

    function automatic logic [COORD_N-1:0] f_blob_row(input int w, input int y);
        logic [COORD_N-1:0] row;
        row = '0;
        for (int x = 0; x < COORD_N; x++) begin
            row[x] = (x < w && y < w) ? f_blob_hit(w, x, y) : 1'b0;
        end
        return row;
    endfunction

    // Exact floor(p / 255) for p below 65280.
    function automatic logic [LEVEL_W-1:0] f_div255(input logic [2*LEVEL_W-1:0] p);
        logic [2*LEVEL_W:0] sum;
        sum = {1'b0, p} + {9'd0, p[2*LEVEL_W-1:LEVEL_W]} + 17'd1;
        return sum[2*LEVEL_W-1:LEVEL_W];
    endfunction

endpackage

`default_nettype wire

>>> design/sspg_if.sv
// ----------------------------------------------------------------------------
// Sprite shape pixel generator channels
// Valid/ready channels for pixel items, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sspg_pix_if import sspg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;

    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface sspg_res_if import sspg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] argb_word;
    logic              covered;

    modport source (output valid, argb_word, covered, input ready);
    modport sink   (input valid, argb_word, covered, output ready);
endinterface

interface sspg_cfg_if import sspg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LEVEL_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/sspg_premul.sv
// ----------------------------------------------------------------------------
// Sprite shape pixel generator premultiply
// Two-stage alpha premultiply of the three color channels and word packing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sspg_premul import sspg_pkg::*; (
    input  wire                i_clk,
    input  t_premul_ctl        i_ctl,
    input  wire [LEVEL_W-1:0]  i_alpha,
    input  wire                i_cov,
    input  wire [LEVEL_W-1:0]  i_red_level,
    input  wire [LEVEL_W-1:0]  i_green_level,
    input  wire [LEVEL_W-1:0]  i_blue_level,
    output logic [WORD_W-1:0]  o_argb_word,
    output logic               o_covered
);

    logic [2*LEVEL_W-1:0] r_prod_r;
    logic [2*LEVEL_W-1:0] r_prod_g;
    logic [2*LEVEL_W-1:0] r_prod_b;
    logic [LEVEL_W-1:0]   r_alpha;
    logic                 r_cov;
    logic [WORD_W-1:0]    r_argb_word;
    logic                 r_covered;
    logic [WORD_W-1:0]    n_argb_word;

    always_comb begin
        n_argb_word = {r_alpha, f_div255(r_prod_r), f_div255(r_prod_g), f_div255(r_prod_b)};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_prod_r <= i_red_level * i_alpha;
            r_prod_g <= i_green_level * i_alpha;
            r_prod_b <= i_blue_level * i_alpha;
            r_alpha  <= i_alpha;
            r_cov    <= i_cov;
        end
        if (i_ctl.ld_out) begin
            r_argb_word <= n_argb_word;
            r_covered   <= r_cov;
        end
    end

    assign o_argb_word = r_argb_word;
    assign o_covered   = r_covered;

endmodule

`default_nettype wire

>>> design/sprite_shape_pixel_generator.sv
// Each pixel item passes stages 1 to 5, then the premultiply and output registers of u_premul.
// Throughput: one item per clock unless o_res stalls; each of the seven stages is registered.
// A stalled output holds each stage that is full, and empty stages keep filling.
// Reset is synchronous and active low; it empties the pipeline and restores the
// register defaults. The shape masks are constant tables, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Sprite shape pixel generator
// Maps a sprite pixel coordinate to its premultiplied ARGB word for a radial
// disc, a five-point star or a stacked-ellipse blob.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sprite_shape_pixel_generator import sspg_pkg::*; #(
    parameter int DISC_SIZE  = 10,
    parameter int SHAPE_SIZE = 30
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sspg_pix_if.sink   i_pix,
    sspg_cfg_if.sink   i_cfg,
    sspg_res_if.source o_res
);

    localparam int     NN       = DISC_SIZE * DISC_SIZE;
    localparam int     NN_W     = $clog2(NN + 1);
    localparam int     P_W      = LEVEL_W + NN_W;
    localparam int     RECIP_SH = 32;
    localparam longint RECIP_L  = (64'sd1 <<< RECIP_SH) / NN;
    localparam int     S_W      = 15;
    localparam int     NSTG     = 7;

    localparam logic [RECIP_SH-1:0]  RECIP  = RECIP_L[RECIP_SH-1:0];
    localparam logic [NN_W-1:0]      NN_C   = NN_W'(NN);
    localparam logic signed [7:0]    DN_C   = 8'(DISC_SIZE);
    localparam logic [COORD_W:0]     DN_LIM = (COORD_W + 1)'(DISC_SIZE);

    // Configuration registers.
    t_shape_mode        r_shape_mode;
    logic [LEVEL_W-1:0] r_red_level;
    logic [LEVEL_W-1:0] r_green_level;
    logic [LEVEL_W-1:0] r_blue_level;
    logic [LEVEL_W-1:0] r_peak_alpha;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_mode  <= MODE_DISC;
            r_red_level   <= 8'd255;
            r_green_level <= 8'd255;
            r_blue_level  <= 8'd255;
            r_peak_alpha  <= 8'd70;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SHAPE_MODE:  r_shape_mode  <= t_shape_mode'(i_cfg.data[1:0]);
                CFG_RED_LEVEL:   r_red_level   <= i_cfg.data;
                CFG_GREEN_LEVEL: r_green_level <= i_cfg.data;
                CFG_BLUE_LEVEL:  r_blue_level  <= i_cfg.data;
                CFG_PEAK_ALPHA:  r_peak_alpha  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Shape mask rows, built at elaboration.
    logic [COORD_N-1:0] w_star_rom [COORD_N];
    logic [COORD_N-1:0] w_blob_rom [COORD_N];

    for (genvar gy = 0; gy < COORD_N; gy++) begin : g_rom
        localparam logic [COORD_N-1:0] STAR_ROW = f_star_row(SHAPE_SIZE, gy);
        localparam logic [COORD_N-1:0] BLOB_ROW = f_blob_row(SHAPE_SIZE, gy);
        assign w_star_rom[gy] = STAR_ROW;
        assign w_blob_rom[gy] = BLOB_ROW;
    end

    // Pipeline flow control.
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_en;
    logic          w_is_disc;

    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || o_res.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[1];
    assign w_is_disc   = (r_shape_mode != MODE_STAR) && (r_shape_mode != MODE_BLOB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_pix.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: coordinate capture.
    logic [COORD_W-1:0] r_s1_col;
    logic [COORD_W-1:0] r_s1_row;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_col <= i_pix.pixel_col;
            r_s1_row <= i_pix.pixel_row;
        end
    end

    // Stage 2: disc radius and mask row lookup.
    logic signed [7:0]  w_dx;
    logic signed [7:0]  w_dy;
    logic signed [15:0] w_dx_sq;
    logic signed [15:0] w_dy_sq;
    logic [S_W-1:0]     n_s2_s;
    logic               n_s2_in_disc;
    logic [COORD_N-1:0] n_s2_mask;
    logic [COORD_W-1:0] r_s2_col;
    logic [S_W-1:0]     r_s2_s;
    logic               r_s2_in_disc;
    logic [COORD_N-1:0] r_s2_mask;

    always_comb begin
        w_dx         = signed'({1'b0, r_s1_col, 1'b1}) - DN_C;
        w_dy         = signed'({1'b0, r_s1_row, 1'b1}) - DN_C;
        w_dx_sq      = w_dx * w_dx;
        w_dy_sq      = w_dy * w_dy;
        n_s2_s       = w_dx_sq[S_W-1:0] + w_dy_sq[S_W-1:0];
        n_s2_in_disc = ({1'b0, r_s1_col} < DN_LIM) && ({1'b0, r_s1_row} < DN_LIM);
        unique case (r_shape_mode)
            MODE_STAR: n_s2_mask = w_star_rom[r_s1_row];
            MODE_BLOB: n_s2_mask = w_blob_rom[r_s1_row];
            default:   n_s2_mask = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_col     <= r_s1_col;
            r_s2_s       <= n_s2_s;
            r_s2_in_disc <= n_s2_in_disc;
            r_s2_mask    <= n_s2_mask;
        end
    end

    // Stage 3: coverage and scaled disc falloff.
    logic            w_disc_cov;
    logic [NN_W-1:0] w_diff;
    logic [P_W-1:0]  n_s3_p;
    logic            n_s3_cov;
    logic [P_W-1:0]  r_s3_p;
    logic            r_s3_cov;

    always_comb begin
        w_disc_cov = r_s2_in_disc && (r_s2_s <= S_W'(NN));
        w_diff     = NN_C - r_s2_s[NN_W-1:0];
        n_s3_p     = w_disc_cov ? (r_peak_alpha * w_diff) : '0;
        n_s3_cov   = w_is_disc ? w_disc_cov : r_s2_mask[r_s2_col];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_p   <= n_s3_p;
            r_s3_cov <= n_s3_cov;
        end
    end

    // Stage 4: quotient estimate by reciprocal multiply.
    logic [P_W+RECIP_SH-1:0] w_q_prod;
    logic [LEVEL_W-1:0]      n_s4_q;
    logic [P_W-1:0]          r_s4_p;
    logic [LEVEL_W-1:0]      r_s4_q;
    logic                    r_s4_cov;

    always_comb begin
        w_q_prod = r_s3_p * RECIP;
        n_s4_q   = w_q_prod[RECIP_SH +: LEVEL_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_p   <= r_s3_p;
            r_s4_q   <= n_s4_q;
            r_s4_cov <= r_s3_cov;
        end
    end

    // Stage 5: quotient correction and alpha selection.
    logic [P_W-1:0]     w_qd;
    logic [P_W-1:0]     w_rem;
    logic [LEVEL_W-1:0] w_disc_alpha;
    logic [LEVEL_W-1:0] n_s5_alpha;
    logic [LEVEL_W-1:0] r_s5_alpha;
    logic               r_s5_cov;

    always_comb begin
        w_qd         = r_s4_q * NN_C;
        w_rem        = r_s4_p - w_qd;
        w_disc_alpha = (w_rem >= P_W'(NN)) ? (r_s4_q + 8'd1) : r_s4_q;
        if (!r_s4_cov) begin
            n_s5_alpha = '0;
        end else if (w_is_disc) begin
            n_s5_alpha = w_disc_alpha;
        end else begin
            n_s5_alpha = r_peak_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_alpha <= n_s5_alpha;
            r_s5_cov   <= r_s4_cov;
        end
    end

    // Stages 6 and 7: premultiply and output register.
    t_premul_ctl w_pm_ctl;

    assign w_pm_ctl.ld_mul = w_en[6];
    assign w_pm_ctl.ld_out = w_en[7];

    sspg_premul u_premul (
        .i_clk         (i_clk),
        .i_ctl         (w_pm_ctl),
        .i_alpha       (r_s5_alpha),
        .i_cov         (r_s5_cov),
        .i_red_level   (r_red_level),
        .i_green_level (r_green_level),
        .i_blue_level  (r_blue_level),
        .o_argb_word   (o_res.argb_word),
        .o_covered     (o_res.covered)
    );

    assign o_res.valid = r_vld[NSTG];

endmodule

`default_nettype wire

>>> design/sspg_chk.sv
// ----------------------------------------------------------------------------
// Sprite shape pixel generator checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sspg_chk import sspg_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_res_valid,
    input wire              i_res_ready,
    input wire [WORD_W-1:0] i_argb_word,
    input wire              i_covered
);

    // A pixel outside the shape carries an all-zero word.
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_covered) |-> (i_argb_word == '0))
        else $error("uncovered pixel with nonzero word");

    // Premultiplied channels never exceed alpha.
    a_color_le_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> ((i_argb_word[23:16] <= i_argb_word[31:24]) &&
                         (i_argb_word[15:8] <= i_argb_word[31:24]) &&
                         (i_argb_word[7:0] <= i_argb_word[31:24])))
        else $error("color channel above alpha");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result dropped while stalled");

endmodule

bind sprite_shape_pixel_generator sspg_chk u_sspg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_argb_word (o_res.argb_word),
    .i_covered   (o_res.covered)
);

`default_nettype wire
